// File: sv/qsv_pkg.sv
// shared types, constants and tables of the state-vector gate engine
`timescale 1ns / 1ps
package qsv_pkg;

  localparam int MAX_QUBITS   = 10;
  localparam int AMP_W        = 18;
  localparam int COEF_W       = 18;
  localparam int FRAC         = 16;
  localparam int ADDR_W       = MAX_QUBITS;
  localparam int DEPTH        = 1 << ADDR_W;
  localparam int CNT_W        = ADDR_W + 1;
  localparam int NQ_W         = 4;
  localparam int WIRE_W       = 5;
  localparam int CODE_W       = 5;
  localparam int ANGLE_W      = 16;
  localparam int IDX_W        = 10;
  localparam int PHASE_W      = ANGLE_W + 1;
  localparam int STATUS_W     = 2;
  localparam int KIND_W       = 2;
  localparam int PROB_W       = 18;
  localparam int PROD_W       = AMP_W + COEF_W;
  localparam int SUM_W        = PROD_W + 2;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 34;
  localparam int STEP_W       = 5;
  localparam int ONE_Q        = 65536;
  localparam int INV_SQRT2_Q  = 46341;
  localparam int CORDIC_START = 652032874;

  localparam logic [KIND_W-1:0] KIND_GATE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAME  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_UNSUP = 2'd3;

  localparam logic [CODE_W-1:0] G_X    = 5'd0;
  localparam logic [CODE_W-1:0] G_Y    = 5'd1;
  localparam logic [CODE_W-1:0] G_Z    = 5'd2;
  localparam logic [CODE_W-1:0] G_H    = 5'd3;
  localparam logic [CODE_W-1:0] G_S    = 5'd4;
  localparam logic [CODE_W-1:0] G_SDG  = 5'd5;
  localparam logic [CODE_W-1:0] G_T    = 5'd6;
  localparam logic [CODE_W-1:0] G_TDG  = 5'd7;
  localparam logic [CODE_W-1:0] G_RX   = 5'd8;
  localparam logic [CODE_W-1:0] G_RY   = 5'd9;
  localparam logic [CODE_W-1:0] G_RZ   = 5'd10;
  localparam logic [CODE_W-1:0] G_P    = 5'd11;
  localparam logic [CODE_W-1:0] G_CX   = 5'd12;
  localparam logic [CODE_W-1:0] G_CY   = 5'd13;
  localparam logic [CODE_W-1:0] G_CZ   = 5'd14;
  localparam logic [CODE_W-1:0] G_SWAP = 5'd15;
  localparam logic [CODE_W-1:0] G_CP   = 5'd16;
  localparam logic [CODE_W-1:0] G_CCX  = 5'd17;

  typedef enum logic [1:0] {OP_GATE, OP_CLEAR, OP_READ, OP_NONE} op_t;
  typedef enum logic [2:0] {CLS_1Q, CLS_CTRL, CLS_DIAG, CLS_SWAP, CLS_CCX} cls_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DISPATCH, ST_TRIG_GO, ST_TRIG_WAIT, ST_SCAN, ST_RD_B,
    ST_LAT_B, ST_RD_W, ST_MUL, ST_ACC, ST_WR_A, ST_WR_B, ST_CLEAR, ST_FINISH
  } bk_state_t;

  typedef struct packed {
    op_t                   op;
    logic [STATUS_W-1:0]   status;
    cls_t                  cls;
    logic [CODE_W-1:0]     code;
    logic [ADDR_W-1:0]     ma;
    logic [ADDR_W-1:0]     mb;
    logic [ADDR_W-1:0]     mt;
    logic [ANGLE_W-1:0]    angle;
    logic [IDX_W-1:0]      idx;
    logic [NQ_W-1:0]       nq;
  } cmd_t;

  typedef struct packed {
    logic [COEF_W-1:0] re;
    logic [COEF_W-1:0] im;
  } coef_t;

  function automatic logic signed [CORDIC_W-1:0] arc_const(input logic [STEP_W-1:0] k);
    logic signed [CORDIC_W-1:0] v;
    unique case (k)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/quantum_state_vector_gate_apply.sv
// top level of the state-vector gate engine
`timescale 1ns / 1ps
// State-vector gate engine for up to ten qubits. It holds 1024 complex amplitudes
// (18-bit signed, 16 fraction bits) in a single-port store, qubit q at index bit q.
// Every item gives exactly one result transfer. A gate item scans all 2^n indices
// and, for each pair it changes, does two store reads, four real output parts
// (two complex amplitudes) on four shared 18x18 multipliers, and two store writes.
// Rotation and phase gates first run the iterative cordic. The store has one
// port. After reset the engine runs a clearing pass over all 1024 entries of
// the store and accepts no item until it ends; configuration writes are taken
// at any time but should only be made while the engine is idle. A two-entry queue
// sits between the input checks and the sweep, and the result register lets the
// next item start while a result waits to be taken.
module quantum_state_vector_gate_apply (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,   // qubits_in_use
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,      // kind
  input  logic [47:0] in_tdata,      // gate_code, qubit_a, qubit_b, qubit_c, angle, amp_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata      // status, amp_real, amp_imag, probability
);

  logic                           q_valid, q_pop, init_busy;
  qsv_pkg::cmd_t                  q_cmd;
  logic [qsv_pkg::STATUS_W-1:0]   status;
  logic [qsv_pkg::AMP_W-1:0]      amp_real, amp_imag;
  logic [qsv_pkg::PROB_W-1:0]     probability;

  // front: checks and classifies each transfer, queues it
  qsv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .kind        (in_tuser),
    .gate_code   (in_tdata[4:0]),
    .qubit_a     (in_tdata[9:5]),
    .qubit_b     (in_tdata[14:10]),
    .qubit_c     (in_tdata[19:15]),
    .angle       (in_tdata[35:20]),
    .amp_index   (in_tdata[45:36]),
    .init_busy   (init_busy),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  // back: sweeps the store and holds the result register
  qsv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_re     (amp_real),
    .out_im     (amp_imag),
    .out_prob   (probability)
  );

  // result packing, lowest field first
  assign out_tdata = {probability, amp_imag, amp_real, status};

endmodule

// File: sv/qsv_front.sv
// front end: config register, item checks and a two-entry command queue
`timescale 1ns / 1ps
module qsv_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [qsv_pkg::NQ_W-1:0]      cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qsv_pkg::KIND_W-1:0]    kind,
  input  logic [qsv_pkg::CODE_W-1:0]    gate_code,
  input  logic [qsv_pkg::WIRE_W-1:0]    qubit_a,
  input  logic [qsv_pkg::WIRE_W-1:0]    qubit_b,
  input  logic [qsv_pkg::WIRE_W-1:0]    qubit_c,
  input  logic [qsv_pkg::ANGLE_W-1:0]   angle,
  input  logic [qsv_pkg::IDX_W-1:0]     amp_index,
  input  logic                          init_busy,
  output logic                          q_valid,
  output qsv_pkg::cmd_t                 q_cmd,
  input  logic                          q_pop
);

  logic [qsv_pkg::NQ_W-1:0]  nq_r;
  logic [qsv_pkg::NQ_W-1:0]  n_eff;
  logic [qsv_pkg::CNT_W-1:0] size_f;
  logic [1:0]                wires;
  logic                      bad_range;
  qsv_pkg::cmd_t             cmd;
  qsv_pkg::cmd_t             fifo_r [2];
  logic                      wp_r, rp_r;
  logic [1:0]                cnt_r;
  logic                      push;
  logic [qsv_pkg::ADDR_W-1:0] one_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nq_r <= qsv_pkg::NQ_W'(qsv_pkg::MAX_QUBITS);
    end else if (cfg_wr_en) begin
      nq_r <= cfg_wr_data;
    end
  end

  // qubit count clamped into the supported range
  always_comb begin
    if (nq_r == '0) begin
      n_eff = qsv_pkg::NQ_W'(1);
    end else if (nq_r > qsv_pkg::NQ_W'(qsv_pkg::MAX_QUBITS)) begin
      n_eff = qsv_pkg::NQ_W'(qsv_pkg::MAX_QUBITS);
    end else begin
      n_eff = nq_r;
    end
    size_f = qsv_pkg::CNT_W'(1) << n_eff;
  end

  assign one_bit = qsv_pkg::ADDR_W'(1);

  always_comb begin
    wires = (gate_code <= qsv_pkg::G_P) ? 2'd1 : ((gate_code <= qsv_pkg::G_CP) ? 2'd2 : 2'd3);
    bad_range = (qubit_a >= qsv_pkg::WIRE_W'(n_eff))
             || ((wires >= 2'd2) && (qubit_b >= qsv_pkg::WIRE_W'(n_eff)))
             || ((wires == 2'd3) && (qubit_c >= qsv_pkg::WIRE_W'(n_eff)));
    cmd        = '0;
    cmd.code   = gate_code;
    cmd.angle  = angle;
    cmd.idx    = amp_index;
    cmd.nq     = n_eff;
    cmd.ma     = one_bit << qubit_a;
    cmd.mb     = (wires >= 2'd2) ? (one_bit << qubit_b) : '0;
    cmd.mt     = (wires == 2'd3) ? (one_bit << qubit_c) : '0;
    cmd.status = qsv_pkg::STATUS_OK;
    cmd.op     = qsv_pkg::OP_NONE;
    if (gate_code <= qsv_pkg::G_P) begin
      cmd.cls = qsv_pkg::CLS_1Q;
    end else if (gate_code == qsv_pkg::G_CX || gate_code == qsv_pkg::G_CY) begin
      cmd.cls = qsv_pkg::CLS_CTRL;
    end else if (gate_code == qsv_pkg::G_CZ || gate_code == qsv_pkg::G_CP) begin
      cmd.cls = qsv_pkg::CLS_DIAG;
    end else if (gate_code == qsv_pkg::G_SWAP) begin
      cmd.cls = qsv_pkg::CLS_SWAP;
    end else begin
      cmd.cls = qsv_pkg::CLS_CCX;
    end
    unique case (kind)
      qsv_pkg::KIND_GATE: begin
        cmd.op = qsv_pkg::OP_GATE;
        if (gate_code > qsv_pkg::G_CCX) begin
          cmd.status = qsv_pkg::STATUS_UNSUP;
        end else if (bad_range) begin
          cmd.status = qsv_pkg::STATUS_RANGE;
        end else if (wires == 2'd2 && qubit_a == qubit_b) begin
          cmd.status = qsv_pkg::STATUS_SAME;
        end
      end
      qsv_pkg::KIND_CLEAR: cmd.op = qsv_pkg::OP_CLEAR;
      qsv_pkg::KIND_READ: begin
        cmd.op = qsv_pkg::OP_READ;
        if (qsv_pkg::CNT_W'(amp_index) >= size_f) begin
          cmd.status = qsv_pkg::STATUS_RANGE;
        end
      end
      default: cmd.status = qsv_pkg::STATUS_UNSUP;
    endcase
  end

  // command queue between the checks and the sweep engine
  assign in_ready = (cnt_r != 2'd2) && !init_busy;
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("command queue over capacity");

endmodule

// File: sv/qsv_cordic.sv
// iterative rotation cordic giving cosine and sine of a binary phase
`timescale 1ns / 1ps
module qsv_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [qsv_pkg::PHASE_W-1:0]        phase,
  output logic                               done,
  output logic [qsv_pkg::COEF_W-1:0]         cos_o,
  output logic [qsv_pkg::COEF_W-1:0]         sin_o
);

  localparam int PS_W = qsv_pkg::PHASE_W + 1;

  logic signed [qsv_pkg::CORDIC_W-1:0] x_r, y_r, z_r, dx, dy;
  logic [qsv_pkg::STEP_W-1:0]          step_r;
  logic                                busy_r, neg_r, done_r;
  logic [qsv_pkg::COEF_W-1:0]          cos_r, sin_r;
  logic signed [PS_W-1:0]              ps, zp;
  logic                                fold;
  logic [qsv_pkg::COEF_W-1:0]          xf, yf;

  // fold quadrants two and three by subtracting pi, quadrant four by subtracting two pi
  always_comb begin
    ps   = $signed({1'b0, phase});
    fold = (ps >= PS_W'(18'sh08000)) && (ps < PS_W'(18'sh18000));
    if (fold) begin
      zp = ps - PS_W'(18'sh10000);
    end else if (ps >= PS_W'(18'sh18000)) begin
      zp = ps - PS_W'(18'sh20000);
    end else begin
      zp = ps;
    end
  end

  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;

  function automatic logic [qsv_pkg::COEF_W-1:0] finish_val(
    input logic signed [qsv_pkg::CORDIC_W-1:0] v, input logic neg);
    logic [qsv_pkg::CORDIC_W-1:0]        mag;
    logic signed [qsv_pkg::CORDIC_W-1:0] r;
    mag = v[qsv_pkg::CORDIC_W-1] ? qsv_pkg::CORDIC_W'(-v) : qsv_pkg::CORDIC_W'(v);
    mag = (mag + qsv_pkg::CORDIC_W'(8192)) >> 14;
    r   = (v[qsv_pkg::CORDIC_W-1] ^ neg) ? -$signed(mag) : $signed(mag);
    if (r > qsv_pkg::CORDIC_W'(qsv_pkg::ONE_Q)) begin
      r = qsv_pkg::CORDIC_W'(qsv_pkg::ONE_Q);
    end else if (r < -qsv_pkg::CORDIC_W'(qsv_pkg::ONE_Q)) begin
      r = -qsv_pkg::CORDIC_W'(qsv_pkg::ONE_Q);
    end
    return r[qsv_pkg::COEF_W-1:0];
  endfunction

  assign xf = finish_val(x_r, neg_r);
  assign yf = finish_val(y_r, neg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == qsv_pkg::STEP_W'(qsv_pkg::CORDIC_STEPS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= qsv_pkg::CORDIC_W'(qsv_pkg::CORDIC_START);
      y_r   <= '0;
      z_r   <= qsv_pkg::CORDIC_W'(zp) <<< 15;
      neg_r <= fold;
    end else if (busy_r) begin
      if (step_r == qsv_pkg::STEP_W'(qsv_pkg::CORDIC_STEPS)) begin
        cos_r <= xf;
        sin_r <= yf;
      end else if (!z_r[qsv_pkg::CORDIC_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - qsv_pkg::arc_const(step_r);
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + qsv_pkg::arc_const(step_r);
      end
    end
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// File: sv/qsv_back.sv
// back end: amplitude store, pair sweep, complex multiply and result register
`timescale 1ns / 1ps
module qsv_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  qsv_pkg::cmd_t                   q_cmd,
  output logic                            q_pop,
  output logic                            init_busy,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [qsv_pkg::STATUS_W-1:0]    out_status,
  output logic [qsv_pkg::AMP_W-1:0]       out_re,
  output logic [qsv_pkg::AMP_W-1:0]       out_im,
  output logic [qsv_pkg::PROB_W-1:0]      out_prob
);

  localparam int AW = qsv_pkg::AMP_W;
  localparam int CW = qsv_pkg::COEF_W;
  localparam int SW = qsv_pkg::SUM_W;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (AW - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
  localparam logic signed [SW-1:0] PROB_HI = SW'((64'sd1 <<< qsv_pkg::PROB_W) - 1);

  qsv_pkg::bk_state_t st_r, st_nxt;
  qsv_pkg::cmd_t      cmd_r;

  logic [2*AW-1:0]               mem [qsv_pkg::DEPTH];
  logic [2*AW-1:0]               rd_data_r, wr_data;
  logic [qsv_pkg::ADDR_W-1:0]    rd_addr, wr_addr;
  logic                          rd_en, wr_en;

  logic [qsv_pkg::CNT_W-1:0]     i_r, size;
  logic [qsv_pkg::ADDR_W-1:0]    i_a, j_r, j_nxt;
  logic                          cond;
  logic [1:0]                    k_r;
  logic [2*AW-1:0]               a_r, b_r;
  qsv_pkg::coef_t                m_r [4];
  qsv_pkg::coef_t                mx [4];
  logic [AW-1:0]                 res_r [4];
  logic [qsv_pkg::PROB_W-1:0]    prob_r;
  logic signed [qsv_pkg::PROD_W-1:0] p_r [4];
  logic signed [CW-1:0]          xo [4];
  logic signed [AW-1:0]          yo [4];
  logic                          cordic_start, cordic_done, needs_trig, out_load, is_read;
  logic [CW-1:0]                 c_v, s_v;
  logic                          out_valid_r;
  logic [qsv_pkg::STATUS_W-1:0]  out_status_r;
  logic [AW-1:0]                 out_re_r, out_im_r;
  logic [qsv_pkg::PROB_W-1:0]    out_prob_r;

  qsv_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .phase ((cmd_r.code == qsv_pkg::G_P || cmd_r.code == qsv_pkg::G_CP)
            ? {cmd_r.angle, 1'b0} : {1'b0, cmd_r.angle}),
    .done  (cordic_done),
    .cos_o (c_v),
    .sin_o (s_v)
  );

  assign i_a     = i_r[qsv_pkg::ADDR_W-1:0];
  assign size    = qsv_pkg::CNT_W'(1) << cmd_r.nq;
  assign is_read = (cmd_r.op == qsv_pkg::OP_READ);
  assign needs_trig = ((cmd_r.cls == qsv_pkg::CLS_1Q) && (cmd_r.code >= qsv_pkg::G_RX))
                   || (cmd_r.code == qsv_pkg::G_CP);

  // which entries a gate touches and their partner entries
  always_comb begin
    unique case (cmd_r.cls)
      qsv_pkg::CLS_1Q: begin
        cond  = (i_a & cmd_r.ma) == '0;
        j_nxt = i_a | cmd_r.ma;
      end
      qsv_pkg::CLS_CTRL: begin
        cond  = ((i_a & cmd_r.ma) != '0) && ((i_a & cmd_r.mb) == '0);
        j_nxt = i_a | cmd_r.mb;
      end
      qsv_pkg::CLS_DIAG: begin
        cond  = ((i_a & cmd_r.ma) != '0) && ((i_a & cmd_r.mb) != '0);
        j_nxt = i_a;
      end
      qsv_pkg::CLS_SWAP: begin
        cond  = ((i_a & cmd_r.ma) != '0) && ((i_a & cmd_r.mb) == '0);
        j_nxt = (i_a ^ cmd_r.ma) | cmd_r.mb;
      end
      default: begin
        cond  = ((i_a & cmd_r.ma) != '0) && ((i_a & cmd_r.mb) != '0)
             && ((i_a & cmd_r.mt) == '0);
        j_nxt = i_a | cmd_r.mt;
      end
    endcase
  end

  // gate matrix, row major
  always_comb begin
    logic [CW-1:0]           one, isq;
    logic [qsv_pkg::CODE_W-1:0] ec;
    one = CW'(qsv_pkg::ONE_Q);
    isq = CW'(qsv_pkg::INV_SQRT2_Q);
    for (int n = 0; n < 4; n++) begin
      mx[n] = '0;
    end
    mx[0].re = one;
    mx[3].re = one;
    unique case (cmd_r.cls)
      qsv_pkg::CLS_1Q:   ec = cmd_r.code;
      qsv_pkg::CLS_CTRL: ec = cmd_r.code - qsv_pkg::G_CX;
      qsv_pkg::CLS_DIAG: ec = (cmd_r.code == qsv_pkg::G_CP) ? qsv_pkg::G_P : qsv_pkg::G_Z;
      default:           ec = qsv_pkg::G_X;
    endcase
    case (ec)
      qsv_pkg::G_X: begin
        mx[0].re = '0; mx[1].re = one; mx[2].re = one; mx[3].re = '0;
      end
      qsv_pkg::G_Y: begin
        mx[0].re = '0; mx[1].im = -one; mx[2].im = one; mx[3].re = '0;
      end
      qsv_pkg::G_Z:   mx[3].re = -one;
      qsv_pkg::G_H: begin
        mx[0].re = isq; mx[1].re = isq; mx[2].re = isq; mx[3].re = -isq;
      end
      qsv_pkg::G_S: begin
        mx[3].re = '0; mx[3].im = one;
      end
      qsv_pkg::G_SDG: begin
        mx[3].re = '0; mx[3].im = -one;
      end
      qsv_pkg::G_T: begin
        mx[3].re = isq; mx[3].im = isq;
      end
      qsv_pkg::G_TDG: begin
        mx[3].re = isq; mx[3].im = -isq;
      end
      qsv_pkg::G_RX: begin
        mx[0].re = c_v; mx[1].im = -s_v; mx[2].im = -s_v; mx[3].re = c_v;
      end
      qsv_pkg::G_RY: begin
        mx[0].re = c_v; mx[1].re = -s_v; mx[2].re = s_v; mx[3].re = c_v;
      end
      qsv_pkg::G_RZ: begin
        mx[0].re = c_v; mx[0].im = -s_v; mx[3].re = c_v; mx[3].im = s_v;
      end
      qsv_pkg::G_P: begin
        mx[3].re = c_v; mx[3].im = s_v;
      end
      default: ;
    endcase
  end

  // operands of the four shared multipliers
  always_comb begin
    qsv_pkg::coef_t mA, mB;
    logic signed [AW-1:0] ar, ai, br, bi;
    mA = k_r[1] ? m_r[2] : m_r[0];
    mB = k_r[1] ? m_r[3] : m_r[1];
    ar = $signed(a_r[2*AW-1:AW]);
    ai = $signed(a_r[AW-1:0]);
    br = $signed(b_r[2*AW-1:AW]);
    bi = $signed(b_r[AW-1:0]);
    if (is_read) begin
      xo[0] = CW'(ar); yo[0] = ar;
      xo[1] = CW'(ai); yo[1] = ai;
      xo[2] = '0;      yo[2] = '0;
      xo[3] = '0;      yo[3] = '0;
    end else if (!k_r[0]) begin
      xo[0] = $signed(mA.re);  yo[0] = ar;
      xo[1] = -$signed(mA.im); yo[1] = ai;
      xo[2] = $signed(mB.re);  yo[2] = br;
      xo[3] = -$signed(mB.im); yo[3] = bi;
    end else begin
      xo[0] = $signed(mA.re);  yo[0] = ai;
      xo[1] = $signed(mA.im);  yo[1] = ar;
      xo[2] = $signed(mB.re);  yo[2] = bi;
      xo[3] = $signed(mB.im);  yo[3] = br;
    end
  end

  // sum, round half away from zero, saturate
  logic signed [SW-1:0] sum, rnd;
  logic [SW-1:0]        mag;
  logic [AW-1:0]        sat_v;
  logic [qsv_pkg::PROB_W-1:0] prob_v;
  always_comb begin
    sum = SW'(p_r[0]) + SW'(p_r[1]) + SW'(p_r[2]) + SW'(p_r[3]);
    mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
    mag = (mag + SW'(1 << (qsv_pkg::FRAC - 1))) >> qsv_pkg::FRAC;
    rnd = sum[SW-1] ? -$signed(mag) : $signed(mag);
    if (rnd > SAT_HI) begin
      sat_v = SAT_HI[AW-1:0];
    end else if (rnd < SAT_LO) begin
      sat_v = SAT_LO[AW-1:0];
    end else begin
      sat_v = rnd[AW-1:0];
    end
    prob_v = (rnd > PROB_HI) ? PROB_HI[qsv_pkg::PROB_W-1:0] : rnd[qsv_pkg::PROB_W-1:0];
  end

  // sequencer
  always_comb begin
    st_nxt       = st_r;
    rd_en        = 1'b0;
    rd_addr      = i_a;
    wr_en        = 1'b0;
    wr_addr      = i_a;
    wr_data      = '0;
    q_pop        = 1'b0;
    cordic_start = 1'b0;
    out_load     = 1'b0;
    unique case (st_r)
      qsv_pkg::ST_INIT, qsv_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = (i_r == '0) ? {AW'(qsv_pkg::ONE_Q), AW'(0)} : '0;
        if (i_r == qsv_pkg::CNT_W'(qsv_pkg::DEPTH - 1)) begin
          st_nxt = (st_r == qsv_pkg::ST_INIT) ? qsv_pkg::ST_IDLE : qsv_pkg::ST_FINISH;
        end
      end
      qsv_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          st_nxt = qsv_pkg::ST_DISPATCH;
        end
      end
      qsv_pkg::ST_DISPATCH: begin
        if (cmd_r.status != qsv_pkg::STATUS_OK || cmd_r.op == qsv_pkg::OP_NONE) begin
          st_nxt = qsv_pkg::ST_FINISH;
        end else if (cmd_r.op == qsv_pkg::OP_CLEAR) begin
          st_nxt = qsv_pkg::ST_CLEAR;
        end else if (is_read) begin
          rd_en   = 1'b1;
          rd_addr = qsv_pkg::ADDR_W'(cmd_r.idx);
          st_nxt  = qsv_pkg::ST_RD_W;
        end else begin
          st_nxt = needs_trig ? qsv_pkg::ST_TRIG_GO : qsv_pkg::ST_SCAN;
        end
      end
      qsv_pkg::ST_TRIG_GO: begin
        cordic_start = 1'b1;
        st_nxt       = qsv_pkg::ST_TRIG_WAIT;
      end
      qsv_pkg::ST_TRIG_WAIT: begin
        if (cordic_done) begin
          st_nxt = qsv_pkg::ST_SCAN;
        end
      end
      qsv_pkg::ST_SCAN: begin
        if (i_r == size) begin
          st_nxt = qsv_pkg::ST_FINISH;
        end else if (cond) begin
          rd_en  = 1'b1;
          st_nxt = qsv_pkg::ST_RD_B;
        end
      end
      qsv_pkg::ST_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = j_r;
        st_nxt  = qsv_pkg::ST_LAT_B;
      end
      qsv_pkg::ST_LAT_B: st_nxt = qsv_pkg::ST_MUL;
      qsv_pkg::ST_RD_W:  st_nxt = qsv_pkg::ST_MUL;
      qsv_pkg::ST_MUL:   st_nxt = qsv_pkg::ST_ACC;
      qsv_pkg::ST_ACC: begin
        if (is_read) begin
          st_nxt = qsv_pkg::ST_FINISH;
        end else if (k_r == 2'd3) begin
          st_nxt = qsv_pkg::ST_WR_A;
        end else begin
          st_nxt = qsv_pkg::ST_MUL;
        end
      end
      qsv_pkg::ST_WR_A: begin
        wr_en   = 1'b1;
        wr_data = {res_r[0], res_r[1]};
        st_nxt  = qsv_pkg::ST_WR_B;
      end
      qsv_pkg::ST_WR_B: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = {res_r[2], res_r[3]};
        st_nxt  = qsv_pkg::ST_SCAN;
      end
      qsv_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          st_nxt   = qsv_pkg::ST_IDLE;
        end
      end
      default: st_nxt = qsv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= qsv_pkg::ST_INIT;
      i_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == qsv_pkg::ST_DISPATCH) begin
        i_r <= '0;
        k_r <= '0;
      end else if (st_r == qsv_pkg::ST_INIT || st_r == qsv_pkg::ST_CLEAR
                   || st_r == qsv_pkg::ST_WR_B) begin
        i_r <= i_r + 1'b1;
      end else if (st_r == qsv_pkg::ST_SCAN && i_r != size && !cond) begin
        i_r <= i_r + 1'b1;
      end
      if (st_r == qsv_pkg::ST_ACC) begin
        k_r <= k_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (st_r == qsv_pkg::ST_SCAN) begin
      j_r <= j_nxt;
    end
    if (st_r == qsv_pkg::ST_RD_B || st_r == qsv_pkg::ST_RD_W) begin
      a_r <= rd_data_r;
    end
    if (st_r == qsv_pkg::ST_LAT_B) begin
      b_r <= rd_data_r;
    end
    if (st_r == qsv_pkg::ST_DISPATCH || (st_r == qsv_pkg::ST_TRIG_WAIT && cordic_done)) begin
      for (int n = 0; n < 4; n++) begin
        m_r[n] <= mx[n];
      end
    end
    if (st_r == qsv_pkg::ST_MUL) begin
      for (int n = 0; n < 4; n++) begin
        p_r[n] <= xo[n] * yo[n];
      end
    end
    if (st_r == qsv_pkg::ST_ACC) begin
      res_r[k_r] <= sat_v;
      prob_r     <= prob_v;
    end
    if (out_load) begin
      out_status_r <= cmd_r.status;
      if (is_read && cmd_r.status == qsv_pkg::STATUS_OK) begin
        out_re_r   <= a_r[2*AW-1:AW];
        out_im_r   <= a_r[AW-1:0];
        out_prob_r <= prob_r;
      end else begin
        out_re_r   <= '0;
        out_im_r   <= '0;
        out_prob_r <= '0;
      end
    end
  end

  assign init_busy  = (st_r == qsv_pkg::ST_INIT);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_re     = out_re_r;
  assign out_im     = out_im_r;
  assign out_prob   = out_prob_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == qsv_pkg::ST_WR_A || st_r == qsv_pkg::ST_WR_B) |-> (qsv_pkg::CNT_W'(wr_addr) < size))
    else $error("sweep write outside the used part of the store");

  assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> (st_r == qsv_pkg::ST_TRIG_WAIT))
    else $error("cordic finished with nobody waiting");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken result");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == qsv_pkg::ST_DISPATCH))
    else $error("command popped outside idle");

endmodule
